// ===== hw/rtl/spq_pkg.sv =====
`timescale 1ns / 1ps

package spq_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = (DEPTH > 2) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int OCC_W    = 5;
   localparam int PRIO_W   = 8;
   localparam int TAG_W    = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic {
      OP_ENQ = 1'b0,
      OP_DEQ = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DEQ_WAIT,
      S_ENQ_CMP,
      S_ENQ_LAST,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [PRIO_W-1:0] prio;
      logic [TAG_W-1:0]  tag;
   } entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

endpackage

// ===== hw/rtl/spq_if.sv =====
`timescale 1ns / 1ps

interface spq_req_if;
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [spq_pkg::PRIO_W-1:0] new_priority;
   logic [spq_pkg::TAG_W-1:0]  new_tag;

   modport source (output valid, output op, output new_priority, output new_tag,
                   input ready);
   modport sink   (input valid, input op, input new_priority, input new_tag,
                   output ready);
endinterface

interface spq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [spq_pkg::STATUS_W-1:0] status;
   logic [spq_pkg::PRIO_W-1:0]   out_priority;
   logic [spq_pkg::TAG_W-1:0]    out_tag;
   logic [spq_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, output status, output out_priority, output out_tag,
                   output occupancy, input ready);
   modport sink   (input valid, input status, input out_priority, input out_tag,
                   input occupancy, output ready);
endinterface

// ===== hw/rtl/sorted_priority_queue.sv =====
`timescale 1ns / 1ps

// Priority queue of up to DEPTH entries kept in descending priority order in a
// single-port-write, registered-read entry memory. Enqueue inserts ahead of the first
// entry of lower or equal priority, dequeue returns the tail (lowest priority, oldest
// among equals); each request gives exactly one response. A request is taken only
// while the sequencer is idle. An enqueue walks from the tail toward its slot moving
// one entry per cycle and passes at most DEPTH - 1 entries. The memory's one read
// and one write per cycle set this pace. A waiting response holds the next request
// back only when that one finishes.

module sorted_priority_queue (
   input logic       clock,
   input logic       reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   spq_pkg::mem_req_type mem_req;
   spq_pkg::entry_type   rd_data;

   spq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .mem_req  (mem_req),
      .rd_data  (rd_data)
   );

   spq_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// ===== hw/rtl/spq_store.sv =====
`timescale 1ns / 1ps

module spq_store (
   input  logic                 clock,
   input  spq_pkg::mem_req_type mem_req,
   output spq_pkg::entry_type   rd_data
);

   spq_pkg::entry_type mem_ff [spq_pkg::DEPTH];
   spq_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem_ff[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/spq_seq.sv =====
`timescale 1ns / 1ps

module spq_seq (
   input  logic                 clock,
   input  logic                 reset,
   spq_req_if.sink              req_chan,
   spq_rsp_if.source            rsp_chan,
   output spq_pkg::mem_req_type mem_req,
   input  spq_pkg::entry_type   rd_data
);

   spq_pkg::state_type         state_ff, state_in;
   logic [spq_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [spq_pkg::IDX_W-1:0]  idx_ff, idx_in;
   spq_pkg::entry_type         new_ff, new_in;
   spq_pkg::status_type        res_status_ff, res_status_in;
   spq_pkg::entry_type         res_entry_ff, res_entry_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   spq_pkg::status_type        rsp_status_ff, rsp_status_in;
   spq_pkg::entry_type         rsp_entry_ff, rsp_entry_in;
   logic [spq_pkg::OCC_W-1:0]  rsp_occ_ff, rsp_occ_in;
   logic                       accept;
   logic                       rd_greater;

   assign req_chan.ready = (state_ff == spq_pkg::S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;

   // compare unit: stored entry outranks the new one
   assign rd_greater = (rd_data.prio > new_ff.prio);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spq_pkg::S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      new_ff        <= new_in;
      res_status_ff <= res_status_in;
      res_entry_ff  <= res_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      new_in        = new_ff;
      res_status_in = res_status_ff;
      res_entry_in  = res_entry_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_occ_in    = rsp_occ_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = idx_ff;
      mem_req.wdata = new_ff;
      mem_req.raddr = spq_pkg::IDX_W'(count_ff - 1'b1);

      unique case (state_ff)
         spq_pkg::S_IDLE: begin
            if (accept) begin
               new_in.prio   = req_chan.new_priority;
               new_in.tag    = req_chan.new_tag;
               res_status_in = spq_pkg::ST_OK;
               res_entry_in  = '0;
               idx_in        = spq_pkg::IDX_W'(count_ff);
               if (req_chan.op == spq_pkg::OP_DEQ) begin
                  if (count_ff == '0) begin
                     res_status_in = spq_pkg::ST_EMPTY;
                     state_in      = spq_pkg::S_RESP;
                  end else begin
                     state_in = spq_pkg::S_DEQ_WAIT;
                  end
               end else if (count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH)) begin
                  res_status_in = spq_pkg::ST_FULL;
                  state_in      = spq_pkg::S_RESP;
               end else if (count_ff == '0) begin
                  state_in = spq_pkg::S_ENQ_LAST;
               end else begin
                  state_in = spq_pkg::S_ENQ_CMP;
               end
            end
         end
         spq_pkg::S_DEQ_WAIT: begin
            res_entry_in = rd_data;
            count_in     = count_ff - 1'b1;
            state_in     = spq_pkg::S_RESP;
         end
         spq_pkg::S_ENQ_CMP: begin
            mem_req.we = 1'b1;
            if (rd_greater) begin
               count_in = count_ff + 1'b1;
               state_in = spq_pkg::S_RESP;
            end else begin
               // move the lower-or-equal entry one slot toward the tail
               mem_req.wdata = rd_data;
               idx_in        = idx_ff - 1'b1;
               mem_req.raddr = idx_ff - 1'b1 - 1'b1;
               if (idx_ff == spq_pkg::IDX_W'(1)) begin
                  state_in = spq_pkg::S_ENQ_LAST;
               end
            end
         end
         spq_pkg::S_ENQ_LAST: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            count_in      = count_ff + 1'b1;
            state_in      = spq_pkg::S_RESP;
         end
         spq_pkg::S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_entry_in  = res_entry_ff;
               rsp_occ_in    = spq_pkg::OCC_W'(count_ff);
               state_in      = spq_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = spq_pkg::S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.status       = rsp_status_ff;
   assign rsp_chan.out_priority = rsp_entry_ff.prio;
   assign rsp_chan.out_tag      = rsp_entry_ff.tag;
   assign rsp_chan.occupancy    = rsp_occ_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= spq_pkg::CNT_W'(spq_pkg::DEPTH))
      else $error("entry count above depth");

   a_cmp_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == spq_pkg::S_ENQ_CMP |-> idx_ff != '0)
      else $error("compare step at head slot");

   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      state_ff == spq_pkg::S_RESP && res_status_ff == spq_pkg::ST_EMPTY |-> count_ff == '0)
      else $error("empty status with entries held");

   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      state_ff == spq_pkg::S_RESP && res_status_ff == spq_pkg::ST_FULL
      |-> count_ff == spq_pkg::CNT_W'(spq_pkg::DEPTH))
      else $error("full status below depth");

   a_write_state: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> state_ff == spq_pkg::S_ENQ_CMP || state_ff == spq_pkg::S_ENQ_LAST)
      else $error("entry write outside enqueue");

endmodule

// ===== tb/sorted_priority_queue_tb.sv =====
`timescale 1ns / 1ps

module sorted_priority_queue_tb;

   typedef struct {
      spq_pkg::status_type        status;
      logic [spq_pkg::PRIO_W-1:0] prio;
      logic [spq_pkg::TAG_W-1:0]  tag;
      logic [spq_pkg::OCC_W-1:0]  occ;
   } queue_result_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   sorted_priority_queue u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the queue, slot 0 highest priority
   logic [spq_pkg::PRIO_W-1:0] model_prio [spq_pkg::DEPTH];
   logic [spq_pkg::TAG_W-1:0]  model_tag  [spq_pkg::DEPTH];
   int                         model_count;

   queue_result_type pending_results [$];

   int error_count;
   int print_count;
   int n_insert;
   int n_remove;
   int n_empty;
   int n_dropped;
   int n_checked;
   int peak_occ;

   // sender burst shaping
   int gap_pct;
   int gap_max;
   int burst_left;

   // receiver stall shaping
   int stall_pct;
   int stall_max;
   int hold_request;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("timeout with %0d responses outstanding", pending_results.size());
      $display("Regression FAIL");
      $finish;
   end

   function automatic queue_result_type queue_model_apply(spq_pkg::op_type op,
                                                          logic [spq_pkg::PRIO_W-1:0] pri,
                                                          logic [spq_pkg::TAG_W-1:0] tag);
      queue_result_type r;
      int               pos;
      int               i;
      r.status = spq_pkg::ST_OK;
      r.prio   = '0;
      r.tag    = '0;
      if (op == spq_pkg::OP_ENQ) begin
         if (model_count >= spq_pkg::DEPTH) begin
            r.status = spq_pkg::ST_FULL;
            n_dropped++;
         end else begin
            pos = 0;
            while (pos < model_count && model_prio[pos] > pri) pos++;
            for (i = model_count; i > pos; i--) begin
               model_prio[i] = model_prio[i-1];
               model_tag[i]  = model_tag[i-1];
            end
            model_prio[pos] = pri;
            model_tag[pos]  = tag;
            model_count++;
            n_insert++;
         end
      end else begin
         if (model_count == 0) begin
            r.status = spq_pkg::ST_EMPTY;
            n_empty++;
         end else begin
            model_count--;
            r.prio = model_prio[model_count];
            r.tag  = model_tag[model_count];
            n_remove++;
         end
      end
      r.occ = model_count[spq_pkg::OCC_W-1:0];
      if (model_count > peak_occ) peak_occ = model_count;
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (print_count < 40) begin
         print_count++;
         $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      queue_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("response with no request outstanding", rsp_bus.status, 0);
         end else begin
            want = pending_results.pop_front();
            n_checked++;
            if (rsp_bus.status !== want.status)
               report_mismatch("status", rsp_bus.status, want.status);
            if (rsp_bus.out_priority !== want.prio)
               report_mismatch("out_priority", rsp_bus.out_priority, want.prio);
            if (rsp_bus.out_tag !== want.tag)
               report_mismatch("out_tag", rsp_bus.out_tag, want.tag);
            if (rsp_bus.occupancy !== want.occ)
               report_mismatch("occupancy", rsp_bus.occupancy, want.occ);
         end
      end
   end

   // receiver: random stall bursts, plus long hold-offs on demand
   initial begin
      int hold_left;
      int stall_left;
      hold_left     = 0;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (reset) begin
            rsp_bus.ready = 1'b0;
         end else if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if ($urandom_range(99) < stall_pct) begin
            rsp_bus.ready = 1'b0;
            stall_left    = $urandom_range(stall_max) ;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   task automatic send_request(spq_pkg::op_type op, logic [spq_pkg::PRIO_W-1:0] pri,
                               logic [spq_pkg::TAG_W-1:0] tag);
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.op           = op;
      req_bus.new_priority = pri;
      req_bus.new_tag      = tag;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(queue_model_apply(op, pri, tag));
   endtask

   task automatic idle_cycles(int n);
      repeat (n) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
   endtask

   task automatic issue_request(spq_pkg::op_type op, logic [spq_pkg::PRIO_W-1:0] pri,
                                logic [spq_pkg::TAG_W-1:0] tag);
      if (burst_left == 0) begin
         if ($urandom_range(99) < gap_pct) idle_cycles($urandom_range(gap_max, 1));
         burst_left = $urandom_range(12, 1);
      end
      burst_left--;
      send_request(op, pri, tag);
   endtask

   function automatic logic [spq_pkg::PRIO_W-1:0] random_priority(int narrow_pct);
      if ($urandom_range(99) < narrow_pct) return spq_pkg::PRIO_W'($urandom_range(3));
      return spq_pkg::PRIO_W'($urandom);
   endfunction

   task automatic random_requests(int n, int enq_pct, int narrow_pct);
      spq_pkg::op_type op;
      repeat (n) begin
         op = ($urandom_range(99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ;
         issue_request(op, random_priority(narrow_pct), spq_pkg::TAG_W'($urandom));
      end
   endtask

   task automatic set_idling(int g_pct, int g_max, int s_pct, int s_max);
      gap_pct   = g_pct;
      gap_max   = g_max;
      stall_pct = s_pct;
      stall_max = s_max;
   endtask

   task automatic test_empty_dequeue();
      set_idling(0, 1, 0, 1);
      issue_request(spq_pkg::OP_DEQ, '1, '1);
      issue_request(spq_pkg::OP_DEQ, '0, '0);
   endtask

   // extremes, ties in several places, then overflow attempts
   task automatic test_fill_to_full();
      logic [spq_pkg::PRIO_W-1:0] pri_list [spq_pkg::DEPTH];
      int                         i;
      pri_list = '{8'd255, 8'd0, 8'd128, 8'd128, 8'd128, 8'd0, 8'd255, 8'd255,
                   8'd1, 8'd254, 8'd127, 8'd0, 8'd200, 8'd50, 8'd50, 8'd128};
      for (i = 0; i < spq_pkg::DEPTH; i++) begin
         issue_request(spq_pkg::OP_ENQ, pri_list[i],
                       (i == 1) ? 8'hff : spq_pkg::TAG_W'(i));
      end
      issue_request(spq_pkg::OP_ENQ, '1, '1);
      issue_request(spq_pkg::OP_ENQ, '0, '0);
   endtask

   task automatic test_drain_ties();
      repeat (4) issue_request(spq_pkg::OP_DEQ, spq_pkg::PRIO_W'($urandom),
                               spq_pkg::TAG_W'($urandom));
   endtask

   task automatic test_random_steady();
      set_idling(0, 1, 0, 1);
      random_requests(300, 55, 20);
   endtask

   // swing between mostly inserts and mostly removals to hit full and empty often
   task automatic test_random_sweep();
      int seg;
      set_idling(40, 6, 30, 5);
      for (seg = 0; seg < 5; seg++) begin
         random_requests(25, 88, 10);
         random_requests(25, 20, 10);
      end
   endtask

   task automatic test_random_ties();
      set_idling(30, 4, 25, 3);
      random_requests(250, 60, 85);
   endtask

   task automatic test_backpressure();
      set_idling(0, 1, 0, 1);
      hold_request = 400;
      random_requests(120, 60, 30);
      set_idling(20, 3, 40, 8);
      hold_request = 150;
      random_requests(130, 50, 30);
   endtask

   task automatic wait_for_drain();
      int waited;
      set_idling(0, 1, 0, 1);
      @(negedge clock);
      req_bus.valid = 1'b0;
      waited = 0;
      while (pending_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);
      if (pending_results.size() != 0)
         report_mismatch("responses never arrived", 0, pending_results.size());
   endtask

   initial begin
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.op           = spq_pkg::OP_ENQ;
      req_bus.new_priority = '0;
      req_bus.new_tag      = '0;
      model_count          = 0;
      error_count          = 0;
      print_count          = 0;
      n_insert             = 0;
      n_remove             = 0;
      n_empty              = 0;
      n_dropped            = 0;
      n_checked            = 0;
      peak_occ             = 0;
      burst_left           = 0;
      hold_request         = 0;
      set_idling(0, 1, 0, 1);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_empty_dequeue();
      test_fill_to_full();
      test_drain_ties();
      test_random_steady();
      test_random_sweep();
      test_random_ties();
      test_backpressure();
      wait_for_drain();

      $display("checked %0d responses: %0d inserts, %0d removals, peak occupancy %0d",
               n_checked, n_insert, n_remove, peak_occ);
      $display("error cases: %0d dequeues on empty, %0d inserts dropped when full",
               n_empty, n_dropped);
      if (error_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_store.sv
hw/rtl/spq_seq.sv
hw/rtl/sorted_priority_queue.sv
tb/sorted_priority_queue_tb.sv
